// ===== rtl/rd_cost_best_mv_select_top_macros.svh =====
// ----------------------------------------------------------------------------
// rd_cost_best_mv_select_top_macros
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
// assertion macros shared by the checker files
// each macro samples on the rising edge of clock
`ifndef RD_COST_BEST_MV_SELECT_TOP_MACROS_SVH
`define RD_COST_BEST_MV_SELECT_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define RDSEL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define RDSEL_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also watches reset itself
`define RDSEL_ASSERT_RST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rdsel_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsel_pkg
// Types, widths, constants and helper functions of the rate-distortion
// best motion vector selector.
// ----------------------------------------------------------------------------
package rdsel_pkg;

   // field widths
   localparam int SAD_W       = 20;
   localparam int MVD_W       = 12;
   localparam int IDX_W       = 8;
   localparam int LAMBDA_W    = 16;
   localparam int MAG_W       = 12;
   localparam int LOG_W       = 12;
   localparam int MVB_W       = 14;
   localparam int FRAC_W      = 8;

   // shared multiplier: 23 x 16 bit unsigned
   localparam int OPA_W       = 23;
   localparam int PROD_W      = OPA_W + LAMBDA_W;
   localparam int COST_W      = 32;

   // stream words
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 8;

   // register port
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam int CSR_IW      = CSR_AW - 2;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_IDX_LAMBDA = 1'b0;

   // constants
   localparam logic [LAMBDA_W-1:0] RESID_MUL    = 16'd1311;
   localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 16'd256;
   localparam logic [MVB_W-1:0]    MV_BIAS      = 14'd512;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RESID,
      ST_WEIGH,
      ST_CMP
   } state_type;

   // magnitude of a two's complement mv difference (most negative gives 2048)
   function automatic logic [MAG_W-1:0] mvd_mag(input logic [MVD_W-1:0] d);
      logic [MAG_W-1:0] u;
      u = MAG_W'(d);
      return d[MVD_W-1] ? MAG_W'(~u + MAG_W'(1)) : u;
   endfunction

   // leading-one position in the upper bits, next 8 bits as a linear fraction
   function automatic logic [LOG_W-1:0] log2_q8(input logic [MAG_W-1:0] v);
      logic [3:0]       p;
      logic [MAG_W-1:0] n;
      p = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) p = 4'(i);
      end
      n = v << (4'(MAG_W - 1) - p);
      return {p, n[MAG_W-2 -: FRAC_W]};
   endfunction

   // motion vector rate term: 2*(lx + ly) + 2.0 in q.8
   function automatic logic [MVB_W-1:0] mv_bits(input logic [LOG_W-1:0] lx,
                                                input logic [LOG_W-1:0] ly);
      logic [LOG_W:0] s;
      s = {1'b0, lx} + {1'b0, ly};
      return {s, 1'b0} + MV_BIAS;
   endfunction

endpackage

// ===== rtl/rd_cost_best_mv_select_top.sv =====
// ----------------------------------------------------------------------------
// rd_cost_best_mv_select_top
// Picks the motion vector candidate with the lowest rate-distortion cost in
// each set and sends its position on the last candidate of the set.
// ----------------------------------------------------------------------------
// steps: accept, residual multiply, lambda multiply, compare; the input takes
//   no new candidate until compare ends; one 23x16 multiplier is shared by both
//   products; the best index word is registered at the compare step of the
//   last candidate, which holds while an earlier index is not taken
// reset: synchronous, lambda returns to 1.0 and the running set is cleared
module rd_cost_best_mv_select_top #(
   parameter int MAX_CANDIDATES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   // candidate stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // sad_value[19:0], mvd_x[31:20], mvd_y[43:32], zero fill [47:44]
   input  logic [rdsel_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tlast,
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // best_index[7:0]
   output logic [rdsel_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rdsel_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [rdsel_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [rdsel_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                             csr_pready
);
   import rdsel_pkg::*;

   localparam int              CNT_W   = $clog2(MAX_CANDIDATES);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_CANDIDATES - 1);

   state_type             state_ff, state_in;
   logic [LAMBDA_W-1:0]   lambda_ff;
   logic [SAD_W-1:0]      sad_ff;
   logic [MVD_W-1:0]      mvx_ff;
   logic [MVD_W-1:0]      mvy_ff;
   logic                  last_ff;
   logic [MVB_W-1:0]      mvb_ff, mvb_in;
   logic [PROD_W-1:0]     prod_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [COST_W-1:0]     best_cost_ff;
   logic [CNT_W-1:0]      best_pos_ff, best_pos_in;
   logic                  rsp_valid_ff;
   logic [IDX_W-1:0]      rsp_index_ff;

   logic                  accept;
   logic                  mul_load;
   logic                  cmp_fire;
   logic [OPA_W-1:0]      mul_a;
   logic [LAMBDA_W-1:0]   mul_b;
   logic [PROD_W-1:0]     mul_prod;
   logic [OPA_W-1:0]      resid;
   logic [PROD_W-9:0]     weighted;
   logic [COST_W-1:0]     cost;
   logic                  win;
   logic [CNT_W+IDX_W-1:0] pos_ext;
   logic                  csr_wr;
   logic [CSR_IW-1:0]     csr_idx;

   assign accept = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_RESID;
         ST_RESID: state_in = ST_WEIGH;
         ST_WEIGH: state_in = ST_CMP;
         ST_CMP:   if (cmp_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and shared multiplier operands
   always_comb begin
      req_tready = 1'b0;
      mul_load   = 1'b0;
      cmp_fire   = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_RESID: begin
            mul_load = 1'b1;
            mul_a    = OPA_W'(sad_ff);
            mul_b    = RESID_MUL;
         end
         ST_WEIGH: begin
            mul_load = 1'b1;
            mul_a    = OPA_W'(mvb_ff) + resid;
            mul_b    = lambda_ff;
         end
         ST_CMP:   cmp_fire = !(last_ff && rsp_valid_ff && !rsp_tready);
         default:  req_tready = 1'b0;
      endcase
   end

   // shared multiplier
   assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   // residual term: sad * 1311 >> 8
   assign resid    = prod_ff[OPA_W+FRAC_W-1:FRAC_W];
   // weighted rate: lambda * (mv bits + residual) >> 8
   assign weighted = prod_ff[PROD_W-1:FRAC_W];
   assign cost     = COST_W'({sad_ff, {FRAC_W{1'b0}}}) + COST_W'(weighted);
   assign win      = cost < best_cost_ff;

   // mv rate term from the two magnitudes
   assign mvb_in = mv_bits(log2_q8(MAG_W'(mvd_mag(mvx_ff) + MAG_W'(1))),
                           log2_q8(MAG_W'(mvd_mag(mvy_ff) + MAG_W'(1))));

   assign best_pos_in = win ? cnt_ff : best_pos_ff;
   assign pos_ext     = {{IDX_W{1'b0}}, best_pos_in};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         best_cost_ff <= '1;
         best_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // running best of the set
         if (cmp_fire) begin
            if (last_ff) begin
               cnt_ff       <= '0;
               best_cost_ff <= '1;
               best_pos_ff  <= '0;
            end else begin
               if (cnt_ff < CNT_TOP) cnt_ff <= cnt_ff + CNT_W'(1);
               if (win) best_cost_ff <= cost;
               best_pos_ff <= best_pos_in;
            end
         end
         // result word
         if (cmp_fire && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         sad_ff  <= req_tdata[SAD_W-1:0];
         mvx_ff  <= req_tdata[SAD_W+MVD_W-1:SAD_W];
         mvy_ff  <= req_tdata[SAD_W+2*MVD_W-1:SAD_W+MVD_W];
         last_ff <= req_tlast;
      end
      if (state_ff == ST_RESID) mvb_ff <= mvb_in;
      if (mul_load) prod_ff <= mul_prod;
      if (cmp_fire && last_ff) rsp_index_ff <= pos_ext[IDX_W-1:0];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;

   // register port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff <= LAMBDA_RESET;
      end else if (csr_wr && (csr_idx == CSR_IDX_LAMBDA)) begin
         lambda_ff <= csr_pwdata[LAMBDA_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_LAMBDA: csr_prdata = CSR_DW'(lambda_ff);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/rdsel_checker.sv =====
// ----------------------------------------------------------------------------
// rdsel_checker
// Port-level checks of the best motion vector selector, bound to the top.
// ----------------------------------------------------------------------------
`include "rd_cost_best_mv_select_top_macros.svh"

module rdsel_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tlast,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rdsel_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import rdsel_pkg::*;

   // stalled result word holds
   `RDSEL_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")

   // a candidate keeps the input closed for the three work steps
   `RDSEL_ASSERT_NXT(a_busy, req_tvalid && req_tready, !req_tready ##1 !req_tready ##1 !req_tready, "input reopened during candidate work")

   // a new result only follows the last candidate of a set
   `RDSEL_ASSERT_IMP(a_rsp_src, $rose(rsp_tvalid), $past(req_tvalid && req_tready && req_tlast, 4), "result without a last candidate")

   // reset leaves the block open with no result pending
   `RDSEL_ASSERT_RST(a_reset, reset, req_tready && !rsp_tvalid, "bad state after reset")

endmodule

bind rd_cost_best_mv_select_top rdsel_checker u_rdsel_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/rd_cost_best_mv_select_top_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rd_cost_best_mv_select_top_checker
// Watches the candidate, best index and register ports of the selector,
// works out the winning position of every candidate set on its own and
// compares each best index word with it. Register reads are checked against
// the lambda value last written.
// ----------------------------------------------------------------------------
module rd_cost_best_mv_select_top_checker #(
   parameter int MAX_CANDIDATES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // sad_value[19:0], mvd_x[31:20], mvd_y[43:32], zero fill [47:44]
   input  logic [rdsel_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // best_index[7:0]
   input  logic [rdsel_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rdsel_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [rdsel_pkg::CSR_DW-1:0]      csr_pwdata,
   input  logic [rdsel_pkg::CSR_DW-1:0]      csr_prdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                pending_count
);

   localparam int          COST_BITS  = 40;
   localparam int          POS_LAST   = MAX_CANDIDATES - 1;
   localparam int          X_LO       = rdsel_pkg::SAD_W;
   localparam int          Y_LO       = rdsel_pkg::SAD_W + rdsel_pkg::MVD_W;
   localparam logic [COST_BITS-1:0] COST_CLEAR = '1;

   // running state of the set being searched
   logic [rdsel_pkg::LAMBDA_W-1:0] lambda_setting;
   int unsigned                    next_position;
   logic [COST_BITS-1:0]           lowest_cost;
   int unsigned                    lowest_position;

   logic [rdsel_pkg::IDX_W-1:0]    best_index_queue[$];
   int                             mismatches = 0;
   logic [COST_BITS-1:0]           word_cost;
   logic [rdsel_pkg::IDX_W-1:0]    want_index;
   logic [rdsel_pkg::CSR_DW-1:0]   lambda_word;
   logic                           csr_hit;

   // magnitude of a 12-bit two's complement difference, -2048 gives 2048
   function automatic logic [11:0] mvd_magnitude(input logic [11:0] d);
      logic [12:0] flipped;
      flipped = 13'h1000 - {1'b0, d};
      return d[11] ? flipped[11:0] : d;
   endfunction

   // leading-one position times 256 plus the 8 bits below it, v >= 1
   function automatic logic [15:0] linear_log2_q8(input logic [12:0] v);
      int         msb;
      logic [7:0] frac;
      msb = 0;
      for (int i = 0; i < 13; i++) begin
         if (v[i]) msb = i;
      end
      if (msb >= 8) frac = 8'(v >> (msb - 8));
      else frac = 8'(v << (8 - msb));
      return 16'(msb * 256) + 16'(frac);
   endfunction

   // rate-distortion cost in q.8
   function automatic logic [COST_BITS-1:0] candidate_cost(
         input logic [19:0] sad, input logic [11:0] dx, input logic [11:0] dy,
         input logic [15:0] lambda);
      logic [63:0] rate_q8;
      logic [63:0] resid_q8;
      logic [63:0] weighted_q8;
      rate_q8 = 64'd2 * (64'(linear_log2_q8(13'(mvd_magnitude(dx)) + 13'd1))
                       + 64'(linear_log2_q8(13'(mvd_magnitude(dy)) + 13'd1))) + 64'd512;
      resid_q8 = (64'(sad) * 64'd1311) >> 8;
      weighted_q8 = (64'(lambda) * (rate_q8 + resid_q8)) >> 8;
      return COST_BITS'((64'(sad) << 8) + weighted_q8);
   endfunction

   task automatic clear_running_set();
      next_position = 0;
      lowest_cost = COST_CLEAR;
      lowest_position = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lambda_setting = rdsel_pkg::LAMBDA_RESET;
         clear_running_set();
         best_index_queue.delete();
      end else begin
         // register port: reads return lambda, writes replace it
         csr_hit = csr_psel && csr_penable && csr_pready
                   && csr_paddr[rdsel_pkg::CSR_AW-1:2] == rdsel_pkg::CSR_IDX_LAMBDA;
         lambda_word = lambda_setting;
         if (csr_hit && !csr_pwrite && csr_prdata !== lambda_word) begin
            $error("lambda_q8: expected %0d, got %0d", lambda_word, csr_prdata);
            mismatches++;
         end
         if (csr_hit && csr_pwrite) lambda_setting = csr_pwdata[rdsel_pkg::LAMBDA_W-1:0];

         // best index word against the oldest finished set
         if (rsp_tvalid && rsp_tready) begin
            if (best_index_queue.size() == 0) begin
               $error("best_index: expected none, got %0d", rsp_tdata);
               mismatches++;
            end else begin
               want_index = best_index_queue.pop_front();
               if (rsp_tdata !== want_index) begin
                  $error("best_index: expected %0d, got %0d", want_index, rsp_tdata);
                  mismatches++;
               end
            end
         end

         // candidate word: strict compare keeps the earlier one on a tie
         if (req_tvalid && req_tready) begin
            word_cost = candidate_cost(req_tdata[rdsel_pkg::SAD_W-1:0],
                                       req_tdata[X_LO +: rdsel_pkg::MVD_W],
                                       req_tdata[Y_LO +: rdsel_pkg::MVD_W],
                                       lambda_setting);
            if (word_cost < lowest_cost) begin
               lowest_cost = word_cost;
               lowest_position = next_position;
            end
            // positions stick at the last one once the set is too long
            if (next_position < POS_LAST) next_position++;
            if (req_tlast) begin
               best_index_queue.push_back(rdsel_pkg::IDX_W'(lowest_position));
               clear_running_set();
            end
         end
      end
      pending_count <= best_index_queue.size();
      fail_count <= mismatches;
   end

endmodule

// ===== dv/rd_cost_best_mv_select_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rd_cost_best_mv_select_top_tb
// Drives candidate sets and lambda settings into the selector under several
// idling patterns: a few hand-picked sets first, then random sets including
// over-long ones. The checker beside the block predicts every best index.
// ----------------------------------------------------------------------------
module rd_cost_best_mv_select_top_tb;

   localparam int PHASES             = 8;
   localparam int ITEMS_PER_PHASE    = 150;
   localparam int PIPE_SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT        = 2000;

   localparam logic [19:0] SAD_MAX  = 20'hFFFFF;
   localparam logic [11:0] MVD_MIN  = 12'h800;   // -2048
   localparam logic [11:0] MVD_MAX  = 12'h7FF;   // 2047
   localparam logic [11:0] MVD_NEG1 = 12'hFFF;   // -1

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   // sad_value[19:0], mvd_x[31:20], mvd_y[43:32], zero fill [47:44]
   logic [rdsel_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                              req_tlast;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   // best_index[7:0]
   logic [rdsel_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [rdsel_pkg::CSR_AW-1:0]      csr_paddr;
   logic [rdsel_pkg::CSR_DW-1:0]      csr_pwdata;
   logic [rdsel_pkg::CSR_DW-1:0]      csr_prdata;
   logic                              csr_pready;

   int          fail_count;
   int          pending_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   int unsigned candidates_sent;
   int          quiet_cycles;

   rd_cost_best_mv_select_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rd_cost_best_mv_select_top_checker u_best_index_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles with no word moving on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** rd_cost_best_mv_select_top: FAILED **");
         $finish;
      end
   end

   // one candidate word, with random idle cycles ahead of it
   task automatic send_candidate(input logic [19:0] sad, input logic [11:0] dx,
                                 input logic [11:0] dy, input logic last_flag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, dy, dx, sad};
      req_tlast <= last_flag;
      do @(posedge clock); while (!req_tready);
      candidates_sent++;
   endtask

   // sender holds off until every best index has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic csr_access(input bit is_write, input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {rdsel_pkg::CSR_IDX_LAMBDA, 2'b00};
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // lambda changes only with the pipeline empty, then read back
   task automatic program_lambda(input logic [15:0] value);
      wait_results_drained();
      repeat (PIPE_SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, value);
      csr_access(1'b0, 16'h0000);
   endtask

   function automatic logic [19:0] pick_sad();
      case ($urandom_range(3))
         0: return 20'($urandom);
         1: return 20'($urandom_range(4095));
         2: return 20'($urandom_range(15));
         default: return $urandom_range(1) ? SAD_MAX : 20'd0;
      endcase
   endfunction

   function automatic logic [11:0] pick_mvd();
      case ($urandom_range(3))
         0: return 12'($urandom);
         1: return 12'($urandom_range(8)) - 12'd4;
         2: begin
            case ($urandom_range(3))
               0: return MVD_MIN;
               1: return MVD_MAX;
               2: return MVD_NEG1;
               default: return 12'd0;
            endcase
         end
         default: return 12'($urandom_range(255)) - 12'd128;
      endcase
   endfunction

   // random set, sometimes repeating the previous candidate to force ties
   task automatic send_random_set(input int set_len);
      logic [19:0] sad;
      logic [11:0] dx;
      logic [11:0] dy;
      sad = '0;
      dx = '0;
      dy = '0;
      for (int i = 0; i < set_len; i++) begin
         if (i == 0 || $urandom_range(7) != 0) begin
            sad = pick_sad();
            dx = pick_mvd();
            dy = pick_mvd();
         end
         send_candidate(sad, dx, dy, i == set_len - 1);
      end
   endtask

   // set longer than the index range; falling sad puts the best past the end
   task automatic send_long_set(input bit falling);
      int set_len;
      set_len = $urandom_range(rdsel_pkg::IDX_W == 8 ? 257 : 2, 290);
      for (int i = 0; i < set_len; i++) begin
         if (falling)
            send_candidate(20'((set_len - i) * 8 + $urandom_range(7)),
                           12'($urandom_range(2)), 12'($urandom_range(2)),
                           i == set_len - 1);
         else
            send_candidate(pick_sad(), pick_mvd(), pick_mvd(), i == set_len - 1);
      end
   endtask

   function automatic logic [15:0] phase_lambda(input int phase);
      case (phase)
         0: return rdsel_pkg::LAMBDA_RESET;
         1: return 16'd0;
         2: return 16'hFFFF;
         4: return 16'd1;
         6: return 16'hFFFF;
         7: return 16'd0;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   initial begin
      int unsigned phase_start;
      int          set_no;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      candidates_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lambda after reset
      csr_access(1'b0, 16'h0000);

      // sets of one at both ends of the fields
      send_candidate(20'd0, 12'd0, 12'd0, 1'b1);
      send_candidate(SAD_MAX, MVD_MIN, MVD_MIN, 1'b1);
      send_candidate(SAD_MAX, MVD_MAX, MVD_MAX, 1'b1);
      // -2048 and 2047 give the same cost, the first stays best
      send_candidate(20'd1000, MVD_MAX, 12'd0, 1'b0);
      send_candidate(20'd1000, MVD_MIN, 12'd0, 1'b1);
      send_candidate(20'd1000, 12'd0, MVD_MIN, 1'b0);
      send_candidate(20'd1000, 12'd0, MVD_MAX, 1'b1);
      // a later winner, then a tie with it
      send_candidate(20'd500, 12'd0, 12'd0, 1'b0);
      send_candidate(20'd400, 12'd0, 12'd0, 1'b0);
      send_candidate(20'd400, 12'd0, 12'd0, 1'b1);
      // rate term against a small sad gain
      send_candidate(20'd10, 12'd100, 12'hF9C, 1'b0);
      send_candidate(20'd11, MVD_NEG1, 12'd1, 1'b0);
      send_candidate(20'd12, 12'd0, 12'd0, 1'b1);
      // mixed extremes, best in the middle
      send_candidate(SAD_MAX, MVD_MAX, MVD_NEG1, 1'b0);
      send_candidate(20'd0, MVD_MIN, MVD_MAX, 1'b0);
      send_candidate(SAD_MAX, 12'd0, 12'd0, 1'b1);

      // random phases, each with its own lambda and idling pattern
      for (int phase = 0; phase < PHASES; phase++) begin
         program_lambda(phase_lambda(phase));
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         phase_start = candidates_sent;
         set_no = 0;
         while (candidates_sent - phase_start < ITEMS_PER_PHASE) begin
            if (set_no == 2 && phase % 3 == 0)
               send_long_set(phase % 2 == 0);
            else
               send_random_set($urandom_range(1, 12));
            if (set_no == 4 || $urandom_range(19) == 0) wait_results_drained();
            set_no++;
         end
      end

      wait_results_drained();
      repeat (PIPE_SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** rd_cost_best_mv_select_top: PASSED **");
      else
         $display("** rd_cost_best_mv_select_top: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rdsel_pkg.sv
rtl/rd_cost_best_mv_select_top.sv
rtl/rdsel_checker.sv
dv/rd_cost_best_mv_select_top_checker.sv
dv/rd_cost_best_mv_select_top_tb.sv
